/* sv/stl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script token lexer package
// Shared lexer modes, token kinds, character codes and character classes.
// ----------------------------------------------------------------------------
package stl_pkg;

    // Lexer mode held between bytes.
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BSTAR,
        MODE_STR,
        MODE_STRESC,
        MODE_NUM,
        MODE_ENDR,
        MODE_NAME
    } t_mode;

    // Token kind carried on the result stream.
    typedef enum logic [3:0] {
        KIND_NONE,
        KIND_OPEN,
        KIND_CLOSE,
        KIND_COMMA,
        KIND_QUOTE,
        KIND_STRING,
        KIND_NUMBER,
        KIND_END,
        KIND_NAME
    } t_kind;

    // Per-token side information passed from the lexer step to the result queue.
    typedef struct packed {
        t_kind kind;
        logic  unterminated;
        logic  last;
    } t_tok_meta;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Digits and dots make up a number.
    function automatic logic is_num(input logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_DOT);
    endfunction

    // Bytes that continue an end run.
    function automatic logic is_end(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
               (c == CH_LF) || (c == CH_SEMI);
    endfunction

    // Bytes that stop a name.
    function automatic logic is_namestop(input logic [7:0] c);
        return (c == CH_OPEN) || (c == CH_CLOSE) || (c == CH_COMMA) || is_end(c);
    endfunction

endpackage

/* sv/stl_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script token lexer step
// Combinational next-state logic for one text byte: new mode, pending token
// and up to two finished tokens.
// ----------------------------------------------------------------------------
module stl_step #(
    parameter int OFFSET_WIDTH = 16
) (
    input  logic [7:0]              i_byte,
    input  stl_pkg::t_mode          i_mode,
    input  logic [OFFSET_WIDTH-1:0] i_pstart,
    input  logic [OFFSET_WIDTH-1:0] i_plen,
    input  logic [OFFSET_WIDTH-1:0] i_pos,
    output stl_pkg::t_mode          o_mode,
    output logic [OFFSET_WIDTH-1:0] o_pstart,
    output logic [OFFSET_WIDTH-1:0] o_plen,
    output logic [1:0]              o_cnt,
    output stl_pkg::t_tok_meta      o_meta0,
    output logic [OFFSET_WIDTH-1:0] o_start0,
    output logic [OFFSET_WIDTH-1:0] o_len0,
    output stl_pkg::t_tok_meta      o_meta1,
    output logic [OFFSET_WIDTH-1:0] o_start1,
    output logic [OFFSET_WIDTH-1:0] o_len1
);

    localparam logic [OFFSET_WIDTH-1:0] LEN_ONE = OFFSET_WIDTH'(1);

    // Token A is the pending token that this byte closes; token B is a
    // one-byte token started by this byte, or the none token at end of text.
    always_comb begin
        logic [OFFSET_WIDTH-1:0] plen_inc;
        logic                    fresh;
        logic                    unt;
        logic                    a_v;
        stl_pkg::t_kind          a_kind;
        logic [OFFSET_WIDTH-1:0] a_len;
        logic                    b_v;
        stl_pkg::t_kind          b_kind;
        logic [OFFSET_WIDTH-1:0] b_len;

        plen_inc = (i_plen == '1) ? i_plen : i_plen + LEN_ONE;
        fresh    = 1'b0;
        unt      = 1'b0;
        a_v      = 1'b0;
        a_kind   = stl_pkg::KIND_NONE;
        a_len    = i_plen;
        b_v      = 1'b0;
        b_kind   = stl_pkg::KIND_NONE;
        b_len    = LEN_ONE;
        o_mode   = i_mode;
        o_pstart = i_pstart;
        o_plen   = i_plen;

        if (i_byte == stl_pkg::CH_NUL) begin
            // End of text: flush the pending token, then a none token.
            unt = (i_mode == stl_pkg::MODE_BLOCK) || (i_mode == stl_pkg::MODE_BSTAR) ||
                  (i_mode == stl_pkg::MODE_STR) || (i_mode == stl_pkg::MODE_STRESC);
            case (i_mode)
                stl_pkg::MODE_STR, stl_pkg::MODE_STRESC: begin
                    a_v    = 1'b1;
                    a_kind = stl_pkg::KIND_STRING;
                end
                stl_pkg::MODE_NUM: begin
                    a_v    = 1'b1;
                    a_kind = stl_pkg::KIND_NUMBER;
                end
                stl_pkg::MODE_ENDR: begin
                    a_v    = 1'b1;
                    a_kind = stl_pkg::KIND_END;
                end
                stl_pkg::MODE_NAME: begin
                    a_v    = 1'b1;
                    a_kind = stl_pkg::KIND_NAME;
                end
                default: begin
                    a_v = 1'b0;
                end
            endcase
            b_v      = 1'b1;
            b_kind   = stl_pkg::KIND_NONE;
            b_len    = '0;
            o_mode   = stl_pkg::MODE_IDLE;
            o_pstart = '0;
            o_plen   = '0;
        end else begin
            // Continue the current mode.
            case (i_mode)
                stl_pkg::MODE_SLASH: begin
                    if (i_byte == stl_pkg::CH_SLASH) begin
                        o_mode = stl_pkg::MODE_LINE;
                    end else if (i_byte == stl_pkg::CH_STAR) begin
                        o_mode = stl_pkg::MODE_BLOCK;
                    end else begin
                        o_mode = stl_pkg::MODE_IDLE;
                        fresh  = 1'b1;
                    end
                end
                stl_pkg::MODE_LINE: begin
                    if ((i_byte == stl_pkg::CH_CR) || (i_byte == stl_pkg::CH_LF)) begin
                        o_mode = stl_pkg::MODE_IDLE;
                        fresh  = 1'b1;
                    end
                end
                stl_pkg::MODE_BLOCK: begin
                    if (i_byte == stl_pkg::CH_STAR) begin
                        o_mode = stl_pkg::MODE_BSTAR;
                    end
                end
                stl_pkg::MODE_BSTAR: begin
                    if (i_byte == stl_pkg::CH_SLASH) begin
                        o_mode = stl_pkg::MODE_IDLE;
                    end else if (i_byte != stl_pkg::CH_STAR) begin
                        o_mode = stl_pkg::MODE_BLOCK;
                    end
                end
                stl_pkg::MODE_STR: begin
                    o_plen = plen_inc;
                    if (i_byte == stl_pkg::CH_BSLASH) begin
                        o_mode = stl_pkg::MODE_STRESC;
                    end else if (i_byte == stl_pkg::CH_DQUOTE) begin
                        a_v    = 1'b1;
                        a_kind = stl_pkg::KIND_STRING;
                        a_len  = plen_inc;
                        o_mode = stl_pkg::MODE_IDLE;
                    end
                end
                stl_pkg::MODE_STRESC: begin
                    o_plen = plen_inc;
                    o_mode = stl_pkg::MODE_STR;
                end
                stl_pkg::MODE_NUM: begin
                    if (stl_pkg::is_num(i_byte)) begin
                        o_plen = plen_inc;
                    end else begin
                        a_v    = 1'b1;
                        a_kind = stl_pkg::KIND_NUMBER;
                        o_mode = stl_pkg::MODE_IDLE;
                        fresh  = 1'b1;
                    end
                end
                stl_pkg::MODE_ENDR: begin
                    if (stl_pkg::is_end(i_byte)) begin
                        o_plen = plen_inc;
                    end else begin
                        a_v    = 1'b1;
                        a_kind = stl_pkg::KIND_END;
                        o_mode = stl_pkg::MODE_IDLE;
                        fresh  = 1'b1;
                    end
                end
                stl_pkg::MODE_NAME: begin
                    if (!stl_pkg::is_namestop(i_byte)) begin
                        o_plen = plen_inc;
                    end else begin
                        a_v    = 1'b1;
                        a_kind = stl_pkg::KIND_NAME;
                        o_mode = stl_pkg::MODE_IDLE;
                        fresh  = 1'b1;
                    end
                end
                default: begin
                    o_mode = stl_pkg::MODE_IDLE;
                    fresh  = 1'b1;
                end
            endcase

            // Lex the byte as the start of something new.
            if (fresh) begin
                if ((i_byte == stl_pkg::CH_SPACE) || (i_byte == stl_pkg::CH_TAB)) begin
                    o_mode = stl_pkg::MODE_IDLE;
                end else if (i_byte == stl_pkg::CH_SLASH) begin
                    o_mode = stl_pkg::MODE_SLASH;
                end else if (i_byte == stl_pkg::CH_OPEN) begin
                    b_v    = 1'b1;
                    b_kind = stl_pkg::KIND_OPEN;
                end else if (i_byte == stl_pkg::CH_CLOSE) begin
                    b_v    = 1'b1;
                    b_kind = stl_pkg::KIND_CLOSE;
                end else if (i_byte == stl_pkg::CH_COMMA) begin
                    b_v    = 1'b1;
                    b_kind = stl_pkg::KIND_COMMA;
                end else if (i_byte == stl_pkg::CH_SQUOTE) begin
                    b_v    = 1'b1;
                    b_kind = stl_pkg::KIND_QUOTE;
                end else begin
                    o_pstart = i_pos;
                    o_plen   = LEN_ONE;
                    if (i_byte == stl_pkg::CH_DQUOTE) begin
                        o_mode = stl_pkg::MODE_STR;
                    end else if (stl_pkg::is_num(i_byte)) begin
                        o_mode = stl_pkg::MODE_NUM;
                    end else if ((i_byte == stl_pkg::CH_SEMI) || (i_byte == stl_pkg::CH_CR) ||
                                 (i_byte == stl_pkg::CH_LF)) begin
                        o_mode = stl_pkg::MODE_ENDR;
                    end else begin
                        o_mode = stl_pkg::MODE_NAME;
                    end
                end
            end
        end

        // Pack the finished tokens in order, the last one flagged.
        o_cnt                = {1'b0, a_v} + {1'b0, b_v};
        o_meta0.kind         = a_v ? a_kind : b_kind;
        o_meta0.unterminated = unt;
        o_meta0.last         = a_v ? !b_v : 1'b1;
        o_start0             = a_v ? i_pstart : i_pos;
        o_len0               = a_v ? a_len : b_len;
        o_meta1.kind         = b_kind;
        o_meta1.unterminated = unt;
        o_meta1.last         = 1'b1;
        o_start1             = i_pos;
        o_len1               = b_len;
    end

endmodule

/* sv/stl_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script token lexer result queue
// Two-entry result register that takes all tokens of one byte at once and
// hands them out one transfer at a time.
// ----------------------------------------------------------------------------
module stl_outq #(
    parameter int OFFSET_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [1:0]              i_cnt,
    input  stl_pkg::t_tok_meta      i_meta0,
    input  logic [OFFSET_WIDTH-1:0] i_start0,
    input  logic [OFFSET_WIDTH-1:0] i_len0,
    input  stl_pkg::t_tok_meta      i_meta1,
    input  logic [OFFSET_WIDTH-1:0] i_start1,
    input  logic [OFFSET_WIDTH-1:0] i_len1,
    input  logic                    i_ready,
    output logic                    o_valid,
    output stl_pkg::t_tok_meta      o_meta,
    output logic [OFFSET_WIDTH-1:0] o_start,
    output logic [OFFSET_WIDTH-1:0] o_len,
    output logic                    o_free
);

    logic [1:0]              r_cnt;
    stl_pkg::t_tok_meta      r_meta  [2];
    logic [OFFSET_WIDTH-1:0] r_start [2];
    logic [OFFSET_WIDTH-1:0] r_len   [2];
    logic                    w_fire;

    assign o_valid = (r_cnt != 2'd0);
    assign o_meta  = r_meta[0];
    assign o_start = r_start[0];
    assign o_len   = r_len[0];
    assign w_fire  = o_valid && i_ready;

    // Room for a new byte's tokens when empty, or once the head entry is the last and leaves.
    assign o_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_fire);

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
        end else if (w_fire) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Payload: load both entries, or shift the second to the head.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_meta[0]  <= i_meta0;
            r_start[0] <= i_start0;
            r_len[0]   <= i_len0;
            r_meta[1]  <= i_meta1;
            r_start[1] <= i_start1;
            r_len[1]   <= i_len1;
        end else if (w_fire) begin
            r_meta[0]  <= r_meta[1];
            r_start[0] <= r_start[1];
            r_len[0]   <= r_len[1];
        end
    end

endmodule

/* sv/script_token_lexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script token lexer
// Streaming tokenizer: one text byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
// A byte's tokens pass through the input register and then the result queue
// registers before they are offered on the result stream.
// Throughput: one byte per cycle while the result stream is ready; a byte that
// finishes two tokens holds the input until the two-entry result queue drains.
// Reset (synchronous, active low) returns the lexer to idle between tokens,
// clears the byte offset and pending token, and empties both stages.
// ----------------------------------------------------------------------------
module script_token_lexer #(
    parameter int OFFSET_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] text_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // token_start, then token_length
    output logic [((2 * OFFSET_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic [4:0]           m_axis_tuser,  // [3:0] token_kind, [4] unterminated
    output logic                 m_axis_tlast   // last_of_run
);

    localparam int TDATA_W = ((2 * OFFSET_WIDTH + 7) / 8) * 8;
    localparam logic [OFFSET_WIDTH-1:0] POS_ONE = OFFSET_WIDTH'(1);

    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    stl_pkg::t_mode          r_mode;
    logic [OFFSET_WIDTH-1:0] r_pstart;
    logic [OFFSET_WIDTH-1:0] r_plen;
    logic [OFFSET_WIDTH-1:0] r_pos;

    stl_pkg::t_mode          n_mode;
    logic [OFFSET_WIDTH-1:0] n_pstart;
    logic [OFFSET_WIDTH-1:0] n_plen;
    logic [1:0]              w_cnt;
    stl_pkg::t_tok_meta      w_meta0;
    stl_pkg::t_tok_meta      w_meta1;
    logic [OFFSET_WIDTH-1:0] w_start0;
    logic [OFFSET_WIDTH-1:0] w_len0;
    logic [OFFSET_WIDTH-1:0] w_start1;
    logic [OFFSET_WIDTH-1:0] w_len1;
    stl_pkg::t_tok_meta      w_out_meta;
    logic [OFFSET_WIDTH-1:0] w_out_start;
    logic [OFFSET_WIDTH-1:0] w_out_len;
    logic                    w_q_free;
    logic                    w_go;

    // The held byte is lexed when the result queue can take its tokens.
    assign w_go          = r_in_valid && w_q_free;
    assign s_axis_tready = !r_in_valid || w_go;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Lexer state, advanced once per lexed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= stl_pkg::MODE_IDLE;
            r_pstart <= '0;
            r_plen   <= '0;
            r_pos    <= '0;
        end else if (w_go) begin
            r_mode   <= n_mode;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_pos    <= r_pos + POS_ONE;
        end
    end

    stl_step #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_step (
        .i_byte   (r_in_byte),
        .i_mode   (r_mode),
        .i_pstart (r_pstart),
        .i_plen   (r_plen),
        .i_pos    (r_pos),
        .o_mode   (n_mode),
        .o_pstart (n_pstart),
        .o_plen   (n_plen),
        .o_cnt    (w_cnt),
        .o_meta0  (w_meta0),
        .o_start0 (w_start0),
        .o_len0   (w_len0),
        .o_meta1  (w_meta1),
        .o_start1 (w_start1),
        .o_len1   (w_len1)
    );

    stl_outq #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_go),
        .i_cnt    (w_cnt),
        .i_meta0  (w_meta0),
        .i_start0 (w_start0),
        .i_len0   (w_len0),
        .i_meta1  (w_meta1),
        .i_start1 (w_start1),
        .i_len1   (w_len1),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_meta   (w_out_meta),
        .o_start  (w_out_start),
        .o_len    (w_out_len),
        .o_free   (w_q_free)
    );

    // Result stream packing.
    assign m_axis_tdata = TDATA_W'({w_out_len, w_out_start});
    assign m_axis_tuser = {w_out_meta.unterminated, w_out_meta.kind};
    assign m_axis_tlast = w_out_meta.last;

    // End of text always leaves the lexer idle with nothing pending.
    a_eot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (r_in_byte == stl_pkg::CH_NUL)) |=>
        ((r_mode == stl_pkg::MODE_IDLE) && (r_plen == '0)))
        else $error("lexer not idle after end of text");

    // The byte offset moves by exactly one per lexed byte.
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> (r_pos == $past(r_pos) + POS_ONE))
        else $error("byte offset did not advance by one");

    // A none token is always the final token of its byte.
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_out_meta.kind == stl_pkg::KIND_NONE)) |-> m_axis_tlast)
        else $error("none token not flagged as last");

    // A byte that finishes two tokens only does so at end of text or when a
    // pending token is cut by a one-byte token.
    a_pair_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (w_cnt == 2'd2)) |-> (!w_meta0.last && w_meta1.last &&
        ((r_mode == stl_pkg::MODE_STR) || (r_mode == stl_pkg::MODE_STRESC) ||
         (r_mode == stl_pkg::MODE_NUM) || (r_mode == stl_pkg::MODE_ENDR) ||
         (r_mode == stl_pkg::MODE_NAME))))
        else $error("token pair from a mode with nothing pending");

endmodule

/* dv/tb_script_token_lexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script token lexer testbench
// Streams text bytes into the lexer with random gaps and random result stalls.
// Every accepted byte is lexed again by a behavioral tokenizer in this bench,
// and every token transfer on the result side is checked in order against it.
// ----------------------------------------------------------------------------
module tb_script_token_lexer;

    // One expected or observed token.
    typedef struct packed {
        stl_pkg::t_kind kind;
        logic [15:0]    start;
        logic [15:0]    len;
        logic           unterm;
        logic           last;
    } t_tok;

    // One text byte waiting to be sent.
    typedef struct {
        logic [7:0] ch;
        bit         drain;
        bit         no_gap;
    } t_feed_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic [4:0]  m_tuser;
    logic        m_last;

    t_feed_item text_feed[$];
    t_tok       tokens_due[$];

    // Tokenizer state mirrored in the bench.
    stl_pkg::t_mode lex_state = stl_pkg::MODE_IDLE;
    logic [15:0]    tok_start = 16'd0;
    logic [15:0]    tok_len = 16'd0;
    logic [15:0]    byte_pos = 16'd0;
    t_tok           step_toks[2];
    int             step_n;

    int errors = 0;
    int bytes_sent = 0;
    int tokens_checked = 0;
    int two_tok_bytes = 0;
    int unterm_ends = 0;
    bit next_drain = 1'b0;
    int feed_gap = 0;
    int feed_calm = 0;
    int sink_stall = 0;
    int sink_calm = 0;

    script_token_lexer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_last)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Character classes of the script language.
    function automatic logic digit_or_dot(input logic [7:0] c);
        return ((c >= stl_pkg::CH_ZERO) && (c <= stl_pkg::CH_NINE)) ||
               (c == stl_pkg::CH_DOT);
    endfunction

    function automatic logic ends_run(input logic [7:0] c);
        return (c == stl_pkg::CH_SEMI) || (c == stl_pkg::CH_CR) ||
               (c == stl_pkg::CH_LF) || (c == stl_pkg::CH_SPACE) ||
               (c == stl_pkg::CH_TAB);
    endfunction

    function automatic logic stops_name(input logic [7:0] c);
        return ends_run(c) || (c == stl_pkg::CH_OPEN) || (c == stl_pkg::CH_CLOSE) ||
               (c == stl_pkg::CH_COMMA);
    endfunction

    // Kind of the token currently being collected, if any.
    function automatic stl_pkg::t_kind held_kind();
        case (lex_state)
            stl_pkg::MODE_STR, stl_pkg::MODE_STRESC: return stl_pkg::KIND_STRING;
            stl_pkg::MODE_NUM:                       return stl_pkg::KIND_NUMBER;
            stl_pkg::MODE_ENDR:                      return stl_pkg::KIND_END;
            stl_pkg::MODE_NAME:                      return stl_pkg::KIND_NAME;
            default:                                 return stl_pkg::KIND_NONE;
        endcase
    endfunction

    function automatic void add_tok(input stl_pkg::t_kind k, input logic [15:0] s,
                                    input logic [15:0] l);
        t_tok t;
        t.kind   = k;
        t.start  = s;
        t.len    = l;
        t.unterm = 1'b0;
        t.last   = 1'b0;
        step_toks[step_n] = t;
        step_n++;
    endfunction

    // Lengths saturate at the top of the offset range.
    function automatic void extend();
        if (tok_len != 16'hFFFF) begin
            tok_len = tok_len + 16'd1;
        end
    endfunction

    function automatic void open_tok(input stl_pkg::t_mode m, input logic [15:0] pos);
        lex_state = m;
        tok_start = pos;
        tok_len   = 16'd1;
    endfunction

    // Lexes one accepted byte and queues the tokens it completes.
    function automatic void lex_byte(input logic [7:0] c);
        logic [15:0]    pos;
        logic           fresh;
        logic           unt;
        stl_pkg::t_kind k;
        pos = byte_pos;
        byte_pos = pos + 16'd1;
        fresh = 1'b0;
        step_n = 0;
        if (c == stl_pkg::CH_NUL) begin
            // End of text: flush what is pending, then the none token.
            unt = (lex_state == stl_pkg::MODE_BLOCK) || (lex_state == stl_pkg::MODE_BSTAR) ||
                  (lex_state == stl_pkg::MODE_STR) || (lex_state == stl_pkg::MODE_STRESC);
            k = held_kind();
            if (k != stl_pkg::KIND_NONE) begin
                add_tok(k, tok_start, tok_len);
            end
            add_tok(stl_pkg::KIND_NONE, pos, 16'd0);
            for (int i = 0; i < step_n; i++) begin
                step_toks[i].unterm = unt;
            end
            lex_state = stl_pkg::MODE_IDLE;
            tok_start = 16'd0;
            tok_len   = 16'd0;
            if (unt) begin
                unterm_ends++;
            end
        end else begin
            case (lex_state)
                stl_pkg::MODE_SLASH: begin
                    if (c == stl_pkg::CH_SLASH) begin
                        lex_state = stl_pkg::MODE_LINE;
                    end else if (c == stl_pkg::CH_STAR) begin
                        lex_state = stl_pkg::MODE_BLOCK;
                    end else begin
                        lex_state = stl_pkg::MODE_IDLE;
                        fresh = 1'b1;
                    end
                end
                stl_pkg::MODE_LINE: begin
                    if ((c == stl_pkg::CH_CR) || (c == stl_pkg::CH_LF)) begin
                        lex_state = stl_pkg::MODE_IDLE;
                        fresh = 1'b1;
                    end
                end
                stl_pkg::MODE_BLOCK: begin
                    if (c == stl_pkg::CH_STAR) begin
                        lex_state = stl_pkg::MODE_BSTAR;
                    end
                end
                stl_pkg::MODE_BSTAR: begin
                    // The closing slash is swallowed here.
                    if (c == stl_pkg::CH_SLASH) begin
                        lex_state = stl_pkg::MODE_IDLE;
                    end else if (c != stl_pkg::CH_STAR) begin
                        lex_state = stl_pkg::MODE_BLOCK;
                    end
                end
                stl_pkg::MODE_STR: begin
                    extend();
                    if (c == stl_pkg::CH_BSLASH) begin
                        lex_state = stl_pkg::MODE_STRESC;
                    end else if (c == stl_pkg::CH_DQUOTE) begin
                        add_tok(stl_pkg::KIND_STRING, tok_start, tok_len);
                        lex_state = stl_pkg::MODE_IDLE;
                    end
                end
                stl_pkg::MODE_STRESC: begin
                    extend();
                    lex_state = stl_pkg::MODE_STR;
                end
                stl_pkg::MODE_NUM: begin
                    if (digit_or_dot(c)) begin
                        extend();
                    end else begin
                        add_tok(stl_pkg::KIND_NUMBER, tok_start, tok_len);
                        lex_state = stl_pkg::MODE_IDLE;
                        fresh = 1'b1;
                    end
                end
                stl_pkg::MODE_ENDR: begin
                    if (ends_run(c)) begin
                        extend();
                    end else begin
                        add_tok(stl_pkg::KIND_END, tok_start, tok_len);
                        lex_state = stl_pkg::MODE_IDLE;
                        fresh = 1'b1;
                    end
                end
                stl_pkg::MODE_NAME: begin
                    if (!stops_name(c)) begin
                        extend();
                    end else begin
                        add_tok(stl_pkg::KIND_NAME, tok_start, tok_len);
                        lex_state = stl_pkg::MODE_IDLE;
                        fresh = 1'b1;
                    end
                end
                default: begin
                    lex_state = stl_pkg::MODE_IDLE;
                    fresh = 1'b1;
                end
            endcase

            // The byte opens something new.
            if (fresh) begin
                if ((c == stl_pkg::CH_SPACE) || (c == stl_pkg::CH_TAB)) begin
                    lex_state = stl_pkg::MODE_IDLE;
                end else if (c == stl_pkg::CH_SLASH) begin
                    lex_state = stl_pkg::MODE_SLASH;
                end else if (c == stl_pkg::CH_OPEN) begin
                    add_tok(stl_pkg::KIND_OPEN, pos, 16'd1);
                end else if (c == stl_pkg::CH_CLOSE) begin
                    add_tok(stl_pkg::KIND_CLOSE, pos, 16'd1);
                end else if (c == stl_pkg::CH_COMMA) begin
                    add_tok(stl_pkg::KIND_COMMA, pos, 16'd1);
                end else if (c == stl_pkg::CH_SQUOTE) begin
                    add_tok(stl_pkg::KIND_QUOTE, pos, 16'd1);
                end else if (c == stl_pkg::CH_DQUOTE) begin
                    open_tok(stl_pkg::MODE_STR, pos);
                end else if (digit_or_dot(c)) begin
                    open_tok(stl_pkg::MODE_NUM, pos);
                end else if ((c == stl_pkg::CH_SEMI) || (c == stl_pkg::CH_CR) ||
                             (c == stl_pkg::CH_LF)) begin
                    open_tok(stl_pkg::MODE_ENDR, pos);
                end else begin
                    open_tok(stl_pkg::MODE_NAME, pos);
                end
            end
        end

        if (step_n > 0) begin
            step_toks[step_n - 1].last = 1'b1;
        end
        for (int i = 0; i < step_n; i++) begin
            tokens_due.push_back(step_toks[i]);
        end
        if (step_n == 2) begin
            two_tok_bytes++;
        end
    endfunction

    // Wait before the next item: mostly random, sometimes a calm stretch.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Byte source: presents one byte at a time and lexes it on transfer.
    always @(posedge i_clk) begin
        t_feed_item nxt;
        logic       v;
        logic [7:0] d;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            s_data  <= 8'h00;
            feed_gap = 0;
        end else begin
            v = s_valid;
            d = s_data;
            if (s_valid && s_ready) begin
                lex_byte(s_data);
                bytes_sent++;
                v = 1'b0;
            end
            if (!v) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                end else if ((text_feed.size() != 0) &&
                             !(text_feed[0].drain && (tokens_due.size() != 0))) begin
                    nxt = text_feed.pop_front();
                    v = 1'b1;
                    d = nxt.ch;
                    feed_gap = nxt.no_gap ? 0 : draw_wait(feed_calm);
                end
            end
            s_valid <= v;
            s_data  <= d;
        end
    end

    // Token sink: stalls at random and checks every transfer in order.
    always @(posedge i_clk) begin
        t_tok got;
        t_tok want;
        logic r;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.kind   = stl_pkg::t_kind'(m_tuser[3:0]);
                got.unterm = m_tuser[4];
                got.start  = m_data[15:0];
                got.len    = m_data[31:16];
                got.last   = m_last;
                tokens_checked++;
                if (tokens_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected token: expected none, got kind %0d start %0d",
                             $time, got.kind, got.start);
                    $display("%0t:                   len %0d", $time, got.len);
                end else begin
                    want = tokens_due.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: token mismatch: expected kind %0d start %0d len %0d",
                                 $time, want.kind, want.start, want.len);
                        $display("%0t:   expected unterm %0b last %0b", $time,
                                 want.unterm, want.last);
                        $display("%0t:   actual kind %0d start %0d len %0d unterm %0b last %0b",
                                 $time, got.kind, got.start, got.len, got.unterm, got.last);
                    end
                end
                sink_stall = draw_wait(sink_calm);
            end
            if (sink_stall > 0) begin
                sink_stall--;
                r = 1'b0;
            end else begin
                r = 1'b1;
            end
            m_ready <= r;
        end
    end

    // Stimulus building blocks.
    task automatic push_byte(input logic [7:0] c, input bit no_gap = 1'b0);
        t_feed_item it;
        it.ch     = c;
        it.drain  = next_drain;
        it.no_gap = no_gap;
        next_drain = 1'b0;
        text_feed.push_back(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] name_head();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (stops_name(c) || digit_or_dot(c) || (c == stl_pkg::CH_SLASH) ||
                   (c == stl_pkg::CH_DQUOTE) || (c == stl_pkg::CH_SQUOTE));
        return c;
    endfunction

    function automatic logic [7:0] name_body();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (stops_name(c));
        return c;
    endfunction

    function automatic logic [7:0] punct();
        case ($urandom_range(0, 3))
            0:       return stl_pkg::CH_OPEN;
            1:       return stl_pkg::CH_CLOSE;
            2:       return stl_pkg::CH_COMMA;
            default: return stl_pkg::CH_SQUOTE;
        endcase
    endfunction

    function automatic logic [7:0] blank();
        case ($urandom_range(0, 4))
            0:       return stl_pkg::CH_SPACE;
            1:       return stl_pkg::CH_TAB;
            2:       return stl_pkg::CH_CR;
            3:       return stl_pkg::CH_LF;
            default: return stl_pkg::CH_SEMI;
        endcase
    endfunction

    // One random piece of script text, mostly well formed.
    task automatic gen_fragment();
        int         n;
        logic [7:0] c;
        logic [7:0] prev;
        next_drain = ($urandom_range(0, 39) == 0);
        case ($urandom_range(0, 19))
            0, 19: begin
                push_byte(punct());
            end
            1, 2: begin
                // Quoted string, with escapes now and then.
                n = $urandom_range(0, 8);
                push_byte(stl_pkg::CH_DQUOTE);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        push_byte(stl_pkg::CH_BSLASH);
                        push_byte(8'($urandom_range(1, 255)));
                    end else begin
                        do begin
                            c = 8'($urandom_range(1, 255));
                        end while ((c == stl_pkg::CH_DQUOTE) || (c == stl_pkg::CH_BSLASH));
                        push_byte(c);
                    end
                end
                push_byte(stl_pkg::CH_DQUOTE);
            end
            3, 4, 18: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    c = ($urandom_range(0, 4) == 0) ? stl_pkg::CH_DOT :
                        8'(stl_pkg::CH_ZERO + $urandom_range(0, 9));
                    push_byte(c);
                end
            end
            5: begin
                // End run: opener, then trailing blanks and semicolons.
                case ($urandom_range(0, 2))
                    0:       push_byte(stl_pkg::CH_SEMI);
                    1:       push_byte(stl_pkg::CH_CR);
                    default: push_byte(stl_pkg::CH_LF);
                endcase
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++) begin
                    push_byte(blank());
                end
            end
            6, 7, 8: begin
                n = $urandom_range(0, 7);
                push_byte(name_head());
                for (int i = 0; i < n; i++) begin
                    push_byte(name_body());
                end
            end
            9, 10: begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    push_byte(($urandom_range(0, 1) == 0) ? stl_pkg::CH_SPACE :
                                                            stl_pkg::CH_TAB);
                end
            end
            11: begin
                push_byte(stl_pkg::CH_SLASH);
                push_byte(stl_pkg::CH_SLASH);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    do begin
                        c = 8'($urandom_range(1, 255));
                    end while ((c == stl_pkg::CH_CR) || (c == stl_pkg::CH_LF));
                    push_byte(c);
                end
                push_byte(($urandom_range(0, 1) == 0) ? stl_pkg::CH_CR : stl_pkg::CH_LF);
            end
            12: begin
                push_byte(stl_pkg::CH_SLASH);
                push_byte(stl_pkg::CH_STAR);
                n = $urandom_range(0, 6);
                prev = stl_pkg::CH_NUL;
                for (int i = 0; i < n; i++) begin
                    c = 8'($urandom_range(1, 255));
                    if ((prev == stl_pkg::CH_STAR) && (c == stl_pkg::CH_SLASH)) begin
                        c = stl_pkg::CH_DOT;
                    end
                    push_byte(c);
                    prev = c;
                end
                push_byte(stl_pkg::CH_STAR);
                push_byte(stl_pkg::CH_SLASH);
            end
            13: begin
                push_byte(stl_pkg::CH_SLASH);
                push_byte(stl_pkg::CH_SPACE);
            end
            14: begin
                push_byte(stl_pkg::CH_NUL);
            end
            15: begin
                // Text that ends inside a string or a block comment.
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 1) == 0) begin
                        push_byte(stl_pkg::CH_DQUOTE);
                    end else begin
                        push_byte(stl_pkg::CH_SLASH);
                        push_byte(stl_pkg::CH_STAR);
                    end
                    n = $urandom_range(0, 3);
                    for (int i = 0; i < n; i++) begin
                        push_byte(name_body());
                    end
                    push_byte(stl_pkg::CH_NUL);
                end
            end
            default: begin
                // Raw noise over the whole byte range.
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    push_byte(8'($urandom_range(0, 255)));
                end
            end
        endcase
    endtask

    // Stimulus, reset and end of run.
    initial begin
        // Directed: one-byte tokens, escaped quote, number, end run, name with
        // a slash, lone slash, line and block comments, top byte, flushes.
        push_text("(),'");
        push_text("\"a\\\"b\"");
        push_text("1.5;");
        push_byte(stl_pkg::CH_CR);
        push_byte(stl_pkg::CH_SPACE);
        push_text("x/");
        push_byte(stl_pkg::CH_TAB);
        push_text("/ //c");
        push_byte(stl_pkg::CH_LF);
        push_text("/**/");
        push_byte(8'hFF);
        push_byte(stl_pkg::CH_NUL);
        push_text("\"q");
        push_byte(stl_pkg::CH_NUL);
        push_text("/*");
        push_byte(stl_pkg::CH_NUL);

        while (text_feed.size() < 650) begin
            gen_fragment();
        end

        // Let every token drain before the closing end of text.
        next_drain = 1'b1;
        push_byte(stl_pkg::CH_NUL);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((text_feed.size() != 0) || s_valid) begin
            @(posedge i_clk);
        end
        while (tokens_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);

        $display("Sent %0d text bytes and checked %0d tokens.", bytes_sent, tokens_checked);
        $display("Bytes giving two tokens: %0d, text ends inside string or comment: %0d.",
                 two_tok_bytes, unterm_ends);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
sv/stl_pkg.sv
sv/stl_step.sv
sv/stl_outq.sv
sv/script_token_lexer.sv
dv/tb_script_token_lexer.sv
